// File: src/rlfd_pkg.sv
// Package for the run-length fill decoder: fill command type, record phase
// codes and stream constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlfd_pkg;

  localparam logic [7:0] ESCAPE_BYTE  = 8'd255;
  localparam logic [1:0] ESCAPE_BYTES = 2'd3;
  localparam int         LEN_W        = 24;
  localparam int         ADDR_W       = 24;

  localparam logic [1:0] PHASE_LENGTH = 2'd0;
  localparam logic [1:0] PHASE_EXTEND = 2'd1;
  localparam logic [1:0] PHASE_VALUE  = 2'd2;

  // One command from the byte parser to the fill generator.
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [7:0]       value;
    logic             last;
    logic             trunc;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/rlfd_ifs.sv
// Channel interfaces of the run-length fill decoder: the compressed byte
// channel and the fill command channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rlfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface rlfd_fill_if;
  logic        valid;
  logic        ready;
  logic [23:0] start_address;
  logic [23:0] run_length;
  logic [7:0]  fill_value;
  logic        overrun;
  logic        truncated;
  logic        stream_done;

  modport source (output valid, output start_address, output run_length,
                  output fill_value, output overrun, output truncated,
                  output stream_done, input ready);
  modport sink   (input valid, input start_address, input run_length,
                  input fill_value, input overrun, input truncated,
                  input stream_done, output ready);
endinterface

`default_nettype wire

// File: src/rlfd_front.sv
// Byte parser of the run-length fill decoder: tracks the record phase and
// builds run lengths, pushing one command per finished record or stream end.
// Depends on rlfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlfd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           byte_valid,
  output logic                byte_ready,
  input  wire logic [7:0]     byte_in,
  input  wire logic           last_byte,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output rlfd_pkg::cmd_t      cmd
);

  logic [1:0]                 phase_r, phase_nxt;
  logic [1:0]                 ext_cnt_r, ext_cnt_nxt;
  logic [rlfd_pkg::LEN_W-1:0] acc_r, acc_nxt;
  logic                       take;
  logic                       in_value;

  assign byte_ready = cmd_ready;
  assign take       = byte_valid && byte_ready;
  assign in_value   = (phase_r == rlfd_pkg::PHASE_VALUE);

  // A command leaves on the value byte, or on a last byte that ends a record early.
  assign cmd_valid  = byte_valid && (in_value || last_byte);
  assign cmd.length = acc_r;
  assign cmd.value  = byte_in;
  assign cmd.last   = last_byte;
  assign cmd.trunc  = last_byte && !in_value;

  always_comb begin
    phase_nxt   = phase_r;
    ext_cnt_nxt = ext_cnt_r;
    acc_nxt     = acc_r;
    unique case (phase_r)
      rlfd_pkg::PHASE_EXTEND: begin
        acc_nxt     = {acc_r[rlfd_pkg::LEN_W-9:0], byte_in};
        ext_cnt_nxt = ext_cnt_r + 2'd1;
        if (ext_cnt_nxt >= rlfd_pkg::ESCAPE_BYTES) begin
          phase_nxt = rlfd_pkg::PHASE_VALUE;
        end
      end
      rlfd_pkg::PHASE_VALUE: begin
        phase_nxt   = rlfd_pkg::PHASE_LENGTH;
        ext_cnt_nxt = 2'd0;
        acc_nxt     = '0;
      end
      default: begin
        if (byte_in < rlfd_pkg::ESCAPE_BYTE) begin
          acc_nxt   = rlfd_pkg::LEN_W'(byte_in);
          phase_nxt = rlfd_pkg::PHASE_VALUE;
        end else begin
          acc_nxt     = '0;
          ext_cnt_nxt = 2'd0;
          phase_nxt   = rlfd_pkg::PHASE_EXTEND;
        end
      end
    endcase
    if (last_byte) begin
      phase_nxt   = rlfd_pkg::PHASE_LENGTH;
      ext_cnt_nxt = 2'd0;
      acc_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= rlfd_pkg::PHASE_LENGTH;
      ext_cnt_r <= 2'd0;
      acc_r     <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      ext_cnt_r <= ext_cnt_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/rlfd_cmd_fifo.sv
// Two-entry command queue between the byte parser and the fill generator.
// Depends on rlfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlfd_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire rlfd_pkg::cmd_t push_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output rlfd_pkg::cmd_t      pop_cmd
);

  rlfd_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r, count_nxt;
  logic           push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/rlfd_back.sv
// Fill generator of the run-length fill decoder: keeps the write pointer and
// the room left in the store, clips runs and registers each fill command.
// Depends on rlfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlfd_back #(
  parameter int unsigned STORE_BYTES = 16777216
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cmd_valid,
  output logic                              cmd_ready,
  input  wire rlfd_pkg::cmd_t               cmd,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rlfd_pkg::ADDR_W-1:0]       start_address,
  output logic [rlfd_pkg::LEN_W-1:0]        run_length,
  output logic [7:0]                        fill_value,
  output logic                              overrun,
  output logic                              truncated,
  output logic                              stream_done
);

  localparam int PTR_W = $clog2(STORE_BYTES) + 1;
  localparam int CMP_W = (PTR_W > rlfd_pkg::LEN_W) ? PTR_W : rlfd_pkg::LEN_W + 1;
  localparam logic [PTR_W-1:0] STORE_SIZE = PTR_W'(STORE_BYTES);

  logic [PTR_W-1:0]           wp_r, room_r;
  logic                       valid_r;
  logic [rlfd_pkg::ADDR_W-1:0] addr_r;
  logic [rlfd_pkg::LEN_W-1:0] run_r;
  logic [7:0]                 value_r;
  logic                       over_r, trunc_r, done_r;

  logic                       take;
  logic                       over;
  logic [rlfd_pkg::LEN_W-1:0] run;
  logic [rlfd_pkg::LEN_W-1:0] req_len;

  assign cmd_ready = !valid_r || out_ready;
  assign take      = cmd_valid && cmd_ready;

  // A truncation marker asks for no bytes, so it never clips or advances.
  assign req_len = cmd.trunc ? '0 : cmd.length;
  assign over    = CMP_W'(req_len) > CMP_W'(room_r);
  assign run     = over ? rlfd_pkg::LEN_W'(room_r) : req_len;

  always_ff @(posedge clk) begin
    if (take) begin
      addr_r  <= rlfd_pkg::ADDR_W'(wp_r);
      run_r   <= run;
      value_r <= cmd.trunc ? 8'd0 : cmd.value;
      over_r  <= over;
      trunc_r <= cmd.trunc;
      done_r  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      wp_r    <= '0;
      room_r  <= STORE_SIZE;
    end else begin
      if (take) begin
        valid_r <= 1'b1;
        if (cmd.last) begin
          wp_r   <= '0;
          room_r <= STORE_SIZE;
        end else begin
          // The run never exceeds the room, so the narrowing drops only zeros.
          wp_r   <= wp_r + PTR_W'(run);
          room_r <= room_r - PTR_W'(run);
        end
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = valid_r;
  assign start_address = addr_r;
  assign run_length    = run_r;
  assign fill_value    = value_r;
  assign overrun       = over_r;
  assign truncated     = trunc_r;
  assign stream_done   = done_r;

endmodule

`default_nettype wire

// File: src/run_length_fill_decoder_top.sv
// Top level of the run-length fill decoder: byte parser, command queue and
// fill generator. Depends on rlfd_pkg, rlfd_ifs, rlfd_front, rlfd_cmd_fifo
// and rlfd_back.
//
//   Channel  Dir  Payload                                        Transfer when
//   in_ch    in   byte_in[7:0], last_byte                        valid & ready
//   out_ch   out  start_address[23:0], run_length[23:0],         valid & ready
//                 fill_value[7:0], overrun, truncated, stream_done
//
// One byte is taken every cycle while the command queue has room; the parser's
// phase is registered. A fill command passes from the byte that finishes it
// through the two-entry command queue and then the output register.
// Synchronous active-low reset clears the phase, queue, pointer and output valid.
// An output stall backs up first into the queue and only then stops input.
`timescale 1ns / 1ps
`default_nettype none

module run_length_fill_decoder_top #(
  parameter int unsigned STORE_BYTES = 16777216
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rlfd_byte_if.sink   in_ch,
  rlfd_fill_if.source out_ch
);

  logic           front_valid, front_ready;
  rlfd_pkg::cmd_t front_cmd;
  logic           back_valid, back_ready;
  rlfd_pkg::cmd_t back_cmd;

  rlfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .byte_ready (in_ch.ready),
    .byte_in    (in_ch.byte_in),
    .last_byte  (in_ch.last_byte),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready),
    .cmd        (front_cmd)
  );

  rlfd_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  rlfd_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (back_valid),
    .cmd_ready     (back_ready),
    .cmd           (back_cmd),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .start_address (out_ch.start_address),
    .run_length    (out_ch.run_length),
    .fill_value    (out_ch.fill_value),
    .overrun       (out_ch.overrun),
    .truncated     (out_ch.truncated),
    .stream_done   (out_ch.stream_done)
  );

endmodule

`default_nettype wire

// File: bench/rlfd_tb_pkg.sv
// Fill command record and the tracker that predicts and checks the fill
// commands of the run-length fill decoder. Depends on rlfd_pkg.
`timescale 1ns / 1ps

package rlfd_tb_pkg;

  typedef struct packed {
    logic [23:0] start_address;
    logic [23:0] run_length;
    logic [7:0]  fill_value;
    logic        overrun;
    logic        truncated;
    logic        stream_done;
  } fill_cmd_t;

  class fill_tracker;
    logic [24:0] store_bytes;
    logic [1:0]  phase;
    logic [1:0]  ext_count;
    logic [23:0] len_acc;
    logic [24:0] wr_ptr;
    fill_cmd_t   expected_fills[$];
    int          errors;
    int          fills_checked;
    int          clipped_runs;
    int          cut_streams;

    function new(logic [24:0] size);
      store_bytes   = size;
      errors        = 0;
      fills_checked = 0;
      clipped_runs  = 0;
      cut_streams   = 0;
      restart();
    endfunction

    function void restart();
      phase     = rlfd_pkg::PHASE_LENGTH;
      ext_count = 2'd0;
      len_acc   = 24'd0;
      wr_ptr    = 25'd0;
    endfunction

    // Called for every byte transfer; queues the fill command it causes, if any.
    function void take_byte(logic [7:0] b, logic last);
      fill_cmd_t   cmd;
      logic [24:0] room;
      logic [23:0] run;
      bit          done;
      done = 0;
      cmd  = '0;
      case (phase)
        rlfd_pkg::PHASE_EXTEND: begin
          len_acc   = {len_acc[15:0], b};
          ext_count = ext_count + 2'd1;
          if (ext_count >= rlfd_pkg::ESCAPE_BYTES) phase = rlfd_pkg::PHASE_VALUE;
        end
        rlfd_pkg::PHASE_VALUE: begin
          room = (wr_ptr < store_bytes) ? store_bytes - wr_ptr : 25'd0;
          run  = len_acc;
          if ({1'b0, len_acc} > room) begin
            run         = room[23:0];
            cmd.overrun = 1'b1;
          end
          cmd.start_address = wr_ptr[23:0];
          cmd.run_length    = run;
          cmd.fill_value    = b;
          cmd.stream_done   = last;
          wr_ptr    = wr_ptr + {1'b0, run};
          phase     = rlfd_pkg::PHASE_LENGTH;
          len_acc   = 24'd0;
          ext_count = 2'd0;
          done      = 1;
        end
        default: begin
          if (b < rlfd_pkg::ESCAPE_BYTE) begin
            len_acc = {16'd0, b};
            phase   = rlfd_pkg::PHASE_VALUE;
          end else begin
            len_acc   = 24'd0;
            ext_count = 2'd0;
            phase     = rlfd_pkg::PHASE_EXTEND;
          end
        end
      endcase
      if (last) begin
        // A stream that stops inside a record still reports where it stopped.
        if (!done) begin
          cmd               = '0;
          cmd.start_address = wr_ptr[23:0];
          cmd.truncated     = 1'b1;
          cmd.stream_done   = 1'b1;
          done              = 1;
        end
        restart();
      end
      if (done) expected_fills.push_back(cmd);
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_fill(fill_cmd_t got);
      fill_cmd_t want;
      if (expected_fills.size() == 0) begin
        $error("unexpected fill command: start_address 0x%0h run_length 0x%0h value 0x%0h",
               got.start_address, got.run_length, got.fill_value);
        errors++;
        return;
      end
      want = expected_fills.pop_front();
      compare_field("start_address", want.start_address, got.start_address);
      compare_field("run_length", want.run_length, got.run_length);
      compare_field("fill_value", {16'd0, want.fill_value}, {16'd0, got.fill_value});
      compare_field("overrun", {23'd0, want.overrun}, {23'd0, got.overrun});
      compare_field("truncated", {23'd0, want.truncated}, {23'd0, got.truncated});
      compare_field("stream_done", {23'd0, want.stream_done}, {23'd0, got.stream_done});
      fills_checked++;
      if (want.overrun) clipped_runs++;
      if (want.truncated) cut_streams++;
    endfunction
  endclass

endpackage

// File: bench/testbench.sv
// Top of the bench for run_length_fill_decoder_top: drives compressed streams
// with random gaps and output stalls, checks each fill command. Depends on
// rlfd_pkg, rlfd_ifs, rlfd_tb_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned STORE_SIZE   = 16777216;
  localparam int          RANDOM_BYTES = 1900;
  localparam int          DRAIN_CYCLES = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rlfd_byte_if in_ch ();
  rlfd_fill_if out_ch ();

  run_length_fill_decoder_top #(
    .STORE_BYTES(STORE_SIZE)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rlfd_tb_pkg::fill_tracker fills;
  logic [7:0]  stream_bytes[$];
  bit          src_burst;
  bit          sink_burst;
  int          bytes_sent;

  always #5 clk = ~clk;

  // Sends one byte and returns at the edge of its transfer; valid stays high
  // until the next call decides whether to pause.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.byte_in   <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_bytes.size(); i++) begin
      send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    end
    stream_bytes.delete();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (fills.expected_fills.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void put_record(logic [23:0] len, logic [7:0] value, bit use_escape);
    if (!use_escape && len < 24'(rlfd_pkg::ESCAPE_BYTE)) begin
      stream_bytes.push_back(len[7:0]);
    end else begin
      stream_bytes.push_back(rlfd_pkg::ESCAPE_BYTE);
      stream_bytes.push_back(len[23:16]);
      stream_bytes.push_back(len[15:8]);
      stream_bytes.push_back(len[7:0]);
    end
    stream_bytes.push_back(value);
  endfunction

  function automatic logic [23:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 24'd0;
      1:       return 24'd254;
      2:       return 24'd255;
      3, 4, 5: return 24'($urandom_range(0, 254));
      6:       return 24'($urandom_range(256, 70000));
      7:       return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      fills.take_byte(in_ch.byte_in, in_ch.last_byte);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      fills.check_fill('{start_address: out_ch.start_address,
                         run_length:    out_ch.run_length,
                         fill_value:    out_ch.fill_value,
                         overrun:       out_ch.overrun,
                         truncated:     out_ch.truncated,
                         stream_done:   out_ch.stream_done});
    end
  end

  // Receiver: a random stall before each result, with stretches of none.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    sink_burst   = 0;
    forever begin
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 17);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int  target;
    int  style;
    int  cut;
    bit  paused;
    fills           = new(25'(STORE_SIZE));
    in_ch.valid     = 1'b0;
    in_ch.byte_in   = 8'd0;
    in_ch.last_byte = 1'b0;
    src_burst       = 0;
    bytes_sent      = 0;
    paused          = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Zero-length run, longest short run, a maximal escaped run that is
    // clipped at the store end, a run into a full store and an empty run there.
    put_record(24'd0, 8'h00, 0);
    put_record(24'd254, 8'hFF, 0);
    put_record(24'hFFFFFF, 8'hAA, 1);
    put_record(24'd1, 8'h55, 0);
    put_record(24'd0, 8'h3C, 0);
    send_stream();
    // Streams that end after a length byte, inside and at the end of an escape.
    stream_bytes.push_back(8'd7);
    send_stream();
    stream_bytes = '{rlfd_pkg::ESCAPE_BYTE, 8'h12};
    send_stream();
    stream_bytes = '{rlfd_pkg::ESCAPE_BYTE};
    send_stream();
    stream_bytes = '{rlfd_pkg::ESCAPE_BYTE, 8'h00, 8'h00, 8'h05};
    send_stream();
    wait_idle();

    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      src_burst = ($urandom_range(0, 3) == 0);
      style     = $urandom_range(0, 9);
      if (style == 0) begin
        // Raw noise, rich in escape bytes.
        repeat ($urandom_range(1, 12)) begin
          stream_bytes.push_back(($urandom_range(0, 3) == 0) ? rlfd_pkg::ESCAPE_BYTE
                                                              : 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          put_record(pick_length(), 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        if (style == 1) begin
          cut = $urandom_range(0, 4);
          if (cut == 0) begin
            stream_bytes.push_back(8'($urandom_range(0, 254)));
          end else begin
            stream_bytes.push_back(rlfd_pkg::ESCAPE_BYTE);
            repeat (cut - 1) stream_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
      send_stream();
      if (!paused && bytes_sent > target - RANDOM_BYTES / 2) begin
        paused = 1;
        wait_idle();
      end
    end
    wait_idle();

    $display("Sent %0d compressed bytes; checked %0d fill commands, %0d clipped at the",
             bytes_sent, fills.fills_checked, fills.clipped_runs);
    $display("store end and %0d from streams cut short inside a record.", fills.cut_streams);
    if (fills.expected_fills.size() != 0) begin
      $error("%0d fill commands never arrived", fills.expected_fills.size());
    end
    if (fills.errors == 0 && fills.expected_fills.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
